// ===== design/xcrc_pkg.sv =====
// Shared types, constants and codes for the XMODEM-CRC packet receiver.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package xcrc_pkg;

    // Packet geometry
    localparam int PAYLOAD_BYTES = 128;
    localparam int IDX_W         = $clog2(PAYLOAD_BYTES + 3);
    localparam int CRC_HI_POS    = PAYLOAD_BYTES + 2;

    // CRC-16/XMODEM
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Result queue, depth must be a power of two
    localparam int MAX_RESULTS = 3;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    // Line characters
    localparam logic [7:0] CH_SOH   = 8'd1;
    localparam logic [7:0] CH_EOT   = 8'd4;
    localparam logic [7:0] CH_ACK   = 8'd6;
    localparam logic [7:0] CH_NAK   = 8'd21;
    localparam logic [7:0] CH_CAN   = 8'd24;
    localparam logic [7:0] CH_ABORT = 8'd65;
    localparam logic [7:0] CH_CRC   = 8'd67;

    localparam logic [7:0] SEQ_MAX  = 8'hFF;

    // Status codes
    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_END      = 3'd1;
    localparam logic [2:0] ST_SEQ_ERR  = 3'd2;
    localparam logic [2:0] ST_ABORTED  = 3'd3;
    localparam logic [2:0] ST_CANCELED = 3'd4;
    localparam logic [2:0] ST_ERROR    = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_HDR_TMO  = 2'd0;
    localparam logic [1:0] CFG_BYTE_TMO = 2'd1;
    localparam logic [1:0] CFG_MAX_ERR  = 2'd2;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_CANSEEN = 2'd1,
        PH_PACKET  = 2'd2
    } phase_t;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] reply_char;
        logic [2:0] status;
        logic       last;
    } out_word_t;

    // Replies produced by one input word, from control to result queue
    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][7:0] chars;
        logic [2:0]      status;
    } res_t;

endpackage

`default_nettype wire

// ===== design/xcrc_crc.sv =====
// CRC-16/XMODEM update for one byte, MSB first, no reflection.
// Depends on xcrc_pkg for the polynomial.
`timescale 1ns / 1ps
`default_nettype none

module xcrc_crc
    import xcrc_pkg::*;
(
    input  wire logic [15:0] crc_in,
    input  wire logic [7:0]  data_in,
    output logic      [15:0] crc_out
);

    logic [15:0] c;

    // Eight shift/xor steps, one per data bit
    always_comb
    begin
        c = crc_in ^ {data_in, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

// ===== design/xcrc_ctrl.sv =====
// Protocol control: framing, CRC and sequence checks, timeouts, error count.
// Depends on xcrc_pkg and xcrc_crc; emits up to three replies per word.
`timescale 1ns / 1ps
`default_nettype none

module xcrc_ctrl
    import xcrc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire in_word_t    word,
    input  wire logic [31:0] hdr_tmo,
    input  wire logic [31:0] byte_tmo,
    input  wire logic [7:0]  max_err,
    output res_t             res
);

    phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       bn_reg, bn_next;
    logic [7:0]       bc_reg, bc_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       crc_hi_reg, crc_hi_next;
    logic [7:0]       seq_reg, seq_next;
    logic [7:0]       err_reg, err_next;
    logic [31:0]      timer_reg, timer_next;

    logic [15:0]      crc_upd;
    logic [31:0]      limit;
    logic [31:0]      timer_inc;
    logic [7:0]       seq_inc;
    logic             do_err;

    xcrc_crc u_crc (
        .crc_in  (crc_reg),
        .data_in (word.rx_byte),
        .crc_out (crc_upd)
    );

    // Next state and replies for the accepted word
    always_comb
    begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        bn_next     = bn_reg;
        bc_next     = bc_reg;
        crc_next    = crc_reg;
        crc_hi_next = crc_hi_reg;
        seq_next    = seq_reg;
        err_next    = err_reg;
        timer_next  = timer_reg;
        res         = '0;
        res.status  = ST_ACCEPTED;
        do_err      = 1'b0;

        limit     = (phase_reg == PH_PACKET) ? byte_tmo : hdr_tmo;
        if (limit == 32'd0)
            limit = 32'd1;
        timer_inc = (timer_reg == '1) ? timer_reg : timer_reg + 32'd1;
        seq_inc   = (seq_reg == SEQ_MAX) ? 8'd1 : seq_reg + 8'd1;

        if (accept)
        begin
            if (word.action)
            begin
                // timer tick
                timer_next = timer_inc;
                if (timer_inc >= limit)
                    do_err = 1'b1;
            end
            else
            begin
                timer_next = '0;
                unique case (phase_reg)
                    PH_PACKET:
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                        if (idx_reg == IDX_W'(0))
                            bn_next = word.rx_byte;
                        else if (idx_reg == IDX_W'(1))
                            bc_next = word.rx_byte;
                        else if (idx_reg < IDX_W'(CRC_HI_POS))
                            crc_next = crc_upd;
                        else if (idx_reg == IDX_W'(CRC_HI_POS))
                            crc_hi_next = word.rx_byte;
                        else
                        begin
                            // CRC low byte closes the packet
                            phase_next = PH_HEADER;
                            if (bc_reg != ~bn_reg || {crc_hi_reg, word.rx_byte} != crc_reg)
                                do_err = 1'b1;
                            else
                            begin
                                err_next = '0;
                                seq_next = seq_inc;
                                if (bn_reg != seq_inc)
                                begin
                                    res.count    = 2'd1;
                                    res.chars[0] = CH_NAK;
                                    res.status   = ST_SEQ_ERR;
                                end
                                else
                                begin
                                    res.count    = 2'd2;
                                    res.chars[0] = CH_ACK;
                                    res.chars[1] = CH_CRC;
                                    res.status   = ST_ACCEPTED;
                                end
                            end
                        end
                    end
                    PH_CANSEEN:
                    begin
                        phase_next = PH_HEADER;
                        if (word.rx_byte == CH_CAN)
                        begin
                            res.count    = 2'd2;
                            res.chars[0] = CH_CAN;
                            res.chars[1] = CH_CAN;
                            res.status   = ST_CANCELED;
                        end
                        else
                            do_err = 1'b1;
                    end
                    default:
                    begin
                        // awaiting header
                        phase_next = PH_HEADER;
                        if (word.rx_byte == CH_SOH)
                        begin
                            phase_next = PH_PACKET;
                            idx_next   = '0;
                            crc_next   = '0;
                        end
                        else if (word.rx_byte == CH_EOT)
                        begin
                            err_next     = '0;
                            seq_next     = '0;
                            res.count    = 2'd1;
                            res.chars[0] = CH_ACK;
                            res.status   = ST_END;
                        end
                        else if (word.rx_byte == CH_CAN)
                            phase_next = PH_CANSEEN;
                        else if (word.rx_byte == CH_ABORT)
                        begin
                            res.count    = 2'd2;
                            res.chars[0] = CH_ACK;
                            res.chars[1] = CH_ACK;
                            res.status   = ST_ABORTED;
                        end
                        else
                            do_err = 1'b1;
                    end
                endcase
            end
        end

        // Common error path: optional double cancel, then 'C'
        if (do_err)
        begin
            phase_next = PH_HEADER;
            timer_next = '0;
            res.status = ST_ERROR;
            if (err_reg >= max_err)
            begin
                err_next     = '0;
                res.count    = 2'd3;
                res.chars[0] = CH_CAN;
                res.chars[1] = CH_CAN;
                res.chars[2] = CH_CRC;
            end
            else
            begin
                err_next     = err_reg + 8'd1;
                res.count    = 2'd1;
                res.chars[0] = CH_CRC;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            idx_reg    <= '0;
            bn_reg     <= '0;
            bc_reg     <= '0;
            crc_reg    <= '0;
            crc_hi_reg <= '0;
            seq_reg    <= '0;
            err_reg    <= '0;
            timer_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            bn_reg     <= bn_next;
            bc_reg     <= bc_next;
            crc_reg    <= crc_next;
            crc_hi_reg <= crc_hi_next;
            seq_reg    <= seq_next;
            err_reg    <= err_next;
            timer_reg  <= timer_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/xcrc_fifo.sv =====
// Result queue: takes up to three replies per cycle, hands out one per cycle while out_stall is low.
// Depends on xcrc_pkg for the word types and queue depth.
`timescale 1ns / 1ps
`default_nettype none

module xcrc_fifo
    import xcrc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire res_t      res,
    output logic           room,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_word_t      out_data
);

    out_word_t          mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic               pop;

    assign room      = (count_reg <= FIFO_CW'(FIFO_DEPTH - MAX_RESULTS));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(res.count);
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + FIFO_CW'(res.count) - FIFO_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Reply storage, last flag on the final reply of the word
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            if (2'(k) < res.count)
            begin
                mem_reg[FIFO_AW'(wr_ptr_reg + FIFO_AW'(k))] <= '{
                    reply_char: res.chars[k],
                    status:     res.status,
                    last:       (2'(k) == res.count - 2'd1)
                };
            end
        end
    end

    // Never overfilled
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overfilled");

    // Replies only arrive when there was room for a full set
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (res.count != 2'd0) |-> room)
        else $error("replies pushed without room");

    // A lone pop drops the fill count by one
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && res.count == 2'd0) |=> (count_reg == $past(count_reg) - FIFO_CW'(1)))
        else $error("fill count wrong after pop");

endmodule

`default_nettype wire

// ===== design/xmodem_crc_packet_receiver_core.sv =====
// Top level of the XMODEM-CRC packet receiver: config registers and wiring.
// Depends on xcrc_pkg, xcrc_ctrl, xcrc_crc and xcrc_fifo.
//
// Usage:
//   in channel (in_valid/in_stall/in_data): one word per received byte or
//   timer tick. A word is taken when in_valid is high and in_stall low.
//   out channel (out_valid/out_stall/out_data): reply characters with
//   status and a last flag on the final reply caused by one input word.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 header
//   timeout, 1 byte timeout, 2 max errors. Always ready; write while idle.
// Timing:
//   The control logic handles each word combinationally; its replies
//   land in an 8-entry result queue and leave it on out_data in order.
//   The input takes one word per cycle while the queue has room for
//   three replies; the output drains one reply per cycle while out_stall
//   is low, so words that cause replies are paced by the queue.
//   When the receiver stalls, replies wait in the queue and in_stall rises
//   once fewer than three entries are free.
// Reset:
//   Async active low. Phase returns to awaiting header, counters clear,
//   the queue empties and the config registers take 10000, 1000 and 10.
`timescale 1ns / 1ps
`default_nettype none

module xmodem_crc_packet_receiver_core
    import xcrc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_word_t    in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_word_t        out_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    logic [31:0] hdr_tmo_reg;
    logic [31:0] byte_tmo_reg;
    logic [7:0]  max_err_reg;
    logic        room;
    logic        in_accept;
    res_t        res;

    assign cfg_ready = 1'b1;
    assign in_stall  = !room;
    assign in_accept = in_valid && room;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_tmo_reg  <= 32'd10000;
            byte_tmo_reg <= 32'd1000;
            max_err_reg  <= 8'd10;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_HDR_TMO:  hdr_tmo_reg  <= cfg_data;
                CFG_BYTE_TMO: byte_tmo_reg <= cfg_data;
                CFG_MAX_ERR:  max_err_reg  <= cfg_data[7:0];
                default:      ;
            endcase
        end
    end

    xcrc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (in_accept),
        .word     (in_data),
        .hdr_tmo  (hdr_tmo_reg),
        .byte_tmo (byte_tmo_reg),
        .max_err  (max_err_reg),
        .res      (res)
    );

    xcrc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== dv/xmodem_crc_packet_receiver_core_tb.sv =====
// Self-checking testbench for the XMODEM-CRC packet receiver core.
// Uses xcrc_pkg types and codes; a scoreboard class predicts every reply word.
`timescale 1ns / 1ps
`default_nettype none

module xmodem_crc_packet_receiver_core_tb;

    import xcrc_pkg::*;

    localparam int CYCLE_LIMIT      = 100_000;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int PHASE_MIN_WORDS  = 6;

    // Reply predictor and in-order checker
    class xmodem_reply_model;
        logic [31:0] hdr_limit;
        logic [31:0] byte_limit;
        logic [7:0]  err_limit;

        phase_t      ph;
        logic [15:0] idx;
        logic [7:0]  blk_num;
        logic [7:0]  blk_cmp;
        logic [15:0] crc;
        logic [7:0]  crc_hi;
        logic [7:0]  seq;
        logic [7:0]  err_cnt;
        logic [31:0] idle_ticks;

        out_word_t   pending[$];
        int          fail_count;

        function new();
            hdr_limit  = 32'd10000;
            byte_limit = 32'd1000;
            err_limit  = 8'd10;
            ph         = PH_HEADER;
            idx        = '0;
            blk_num    = '0;
            blk_cmp    = '0;
            crc        = '0;
            crc_hi     = '0;
            seq        = '0;
            err_cnt    = '0;
            idle_ticks = '0;
            fail_count = 0;
        endfunction

        function void write_reg(logic [1:0] index, logic [31:0] value);
            case (index)
                CFG_HDR_TMO:  hdr_limit  = value;
                CFG_BYTE_TMO: byte_limit = value;
                CFG_MAX_ERR:  err_limit  = value[7:0];
                default: ;
            endcase
        endfunction

        // CRC-16/XMODEM, one byte, MSB first
        function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            r = c ^ {b, 8'h00};
            for (int k = 0; k < 8; k++)
                r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
            return r;
        endfunction

        function logic [7:0] next_seq();
            return (seq == SEQ_MAX) ? 8'd1 : seq + 8'd1;
        endfunction

        function void push(logic [7:0] ch, logic [2:0] st);
            out_word_t w;
            w.reply_char = ch;
            w.status     = st;
            w.last       = 1'b0;
            pending.push_back(w);
        endfunction

        // Framing or timeout error: maybe a double cancel, then 'C'
        function void line_error();
            ph         = PH_HEADER;
            idle_ticks = '0;
            if (err_cnt >= err_limit)
            begin
                push(CH_CAN, ST_ERROR);
                push(CH_CAN, ST_ERROR);
                err_cnt = '0;
            end
            else
            begin
                err_cnt = err_cnt + 8'd1;
            end
            push(CH_CRC, ST_ERROR);
        endfunction

        function void packet_byte(logic [7:0] b);
            logic [15:0] i;
            i   = idx;
            idx = idx + 16'd1;
            if (i == 0)
            begin
                blk_num = b;
            end
            else if (i == 1)
            begin
                blk_cmp = b;
            end
            else if (i < CRC_HI_POS)
            begin
                crc = crc_step(crc, b);
            end
            else if (i == CRC_HI_POS)
            begin
                crc_hi = b;
            end
            else
            begin
                ph = PH_HEADER;
                if ((blk_cmp ^ blk_num) != 8'hFF || {crc_hi, b} != crc)
                begin
                    line_error();
                end
                else
                begin
                    err_cnt = '0;
                    seq     = next_seq();
                    if (blk_num != seq)
                    begin
                        push(CH_NAK, ST_SEQ_ERR);
                    end
                    else
                    begin
                        push(CH_ACK, ST_ACCEPTED);
                        push(CH_CRC, ST_ACCEPTED);
                    end
                end
            end
        endfunction

        // Accepted input word: advance state and queue its replies
        function void note_word(in_word_t w);
            int          n0;
            logic [31:0] limit;
            n0 = pending.size();
            if (w.action)
            begin
                limit = (ph == PH_PACKET) ? byte_limit : hdr_limit;
                if (limit == 0)
                    limit = 32'd1;
                if (idle_ticks != 32'hFFFF_FFFF)
                    idle_ticks = idle_ticks + 32'd1;
                if (idle_ticks >= limit)
                    line_error();
            end
            else
            begin
                idle_ticks = '0;
                if (ph == PH_PACKET)
                begin
                    packet_byte(w.rx_byte);
                end
                else if (ph == PH_CANSEEN)
                begin
                    ph = PH_HEADER;
                    if (w.rx_byte == CH_CAN)
                    begin
                        push(CH_CAN, ST_CANCELED);
                        push(CH_CAN, ST_CANCELED);
                    end
                    else
                    begin
                        line_error();
                    end
                end
                else
                begin
                    ph = PH_HEADER;
                    if (w.rx_byte == CH_SOH)
                    begin
                        ph  = PH_PACKET;
                        idx = '0;
                        crc = '0;
                    end
                    else if (w.rx_byte == CH_EOT)
                    begin
                        err_cnt = '0;
                        seq     = '0;
                        push(CH_ACK, ST_END);
                    end
                    else if (w.rx_byte == CH_CAN)
                    begin
                        ph = PH_CANSEEN;
                    end
                    else if (w.rx_byte == CH_ABORT)
                    begin
                        push(CH_ACK, ST_ABORTED);
                        push(CH_ACK, ST_ABORTED);
                    end
                    else
                    begin
                        line_error();
                    end
                end
            end
            if (pending.size() > n0)
                pending[pending.size() - 1].last = 1'b1;
        endfunction

        task report_mismatch(input string what);
            if (fail_count < 100)
                $display("MISMATCH at %0t: %s", $time, what);
            fail_count++;
        endtask

        task check_reply(input out_word_t got);
            out_word_t want;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("unexpected reply char %0d status %0d last %0d",
                                          got.reply_char, got.status, got.last));
                return;
            end
            want = pending.pop_front();
            if (got.reply_char !== want.reply_char)
                report_mismatch($sformatf("reply_char %0d, expected %0d",
                                          got.reply_char, want.reply_char));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d",
                                          got.status, want.status));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %0d, expected %0d", got.last, want.last));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_word_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_word_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    xmodem_reply_model reply_sb;
    bit                idle_en;
    bit                hold_request;
    int                words_sent;
    int                cycle_count;

    xmodem_crc_packet_receiver_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Output stall: random bursts, quiet runs, and one long hold on request
    initial
    begin : out_stall_driver
        int stall_left;
        int run_left;
        int hold_left;
        stall_left = 0;
        run_left   = 0;
        hold_left  = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && hold_request)
            begin
                hold_left    = LONG_HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (run_left > 0)
            begin
                run_left--;
                out_stall <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 2) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                run_left = $urandom_range(0, 30);
                out_stall <= 1'b0;
            end
        end
    end

    // Reply checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            reply_sb.check_reply(out_data);
    end

    // Offer one word; returns at the edge where it is taken
    task automatic send_word(input logic action, input logic [7:0] value);
        in_word_t w;
        int       gap;
        w.action  = action;
        w.rx_byte = value;
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 13);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        else
        begin
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        reply_sb.note_word(w);
        words_sent++;
    endtask

    task automatic send_byte(input logic [7:0] value);
        send_word(1'b0, value);
    endtask

    task automatic send_tick();
        send_word(1'b1, 8'($urandom_range(0, 255)));
    endtask

    // SOH frame with optional corruption and ticks between payload bytes
    task automatic send_packet(input logic [7:0] num, input bit bad_cmp, input bit bad_crc,
                               input bit with_ticks);
        logic [15:0] crc;
        logic [7:0]  b;
        crc = '0;
        send_byte(CH_SOH);
        send_byte(num);
        send_byte(bad_cmp ? (~num ^ (8'h01 << $urandom_range(0, 7))) : ~num);
        for (int i = 0; i < PAYLOAD_BYTES; i++)
        begin
            // control characters inside the payload are plain data
            if ($urandom_range(0, 7) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       b = CH_SOH;
                    1:       b = CH_EOT;
                    2:       b = CH_CAN;
                    default: b = CH_ABORT;
                endcase
            end
            else
            begin
                b = 8'($urandom_range(0, 255));
            end
            crc = reply_sb.crc_step(crc, b);
            if (with_ticks && $urandom_range(0, 15) == 0)
                repeat ($urandom_range(1, 3)) send_tick();
            send_byte(b);
        end
        if (bad_crc)
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        send_byte(crc[15:8]);
        send_byte(crc[7:0]);
    endtask

    // Short header traffic: cut-off frames, control bytes, line noise, ticks
    task automatic send_random_sequence();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 12)
        begin
            send_byte(CH_SOH);
            repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 255)));
            repeat ($urandom_range(1, 6)) send_tick();
        end
        else if (roll < 27)
            send_byte(CH_EOT);
        else if (roll < 40)
            send_byte(CH_ABORT);
        else if (roll < 55)
        begin
            send_byte(CH_CAN);
            send_byte(CH_CAN);
        end
        else if (roll < 65)
        begin
            send_byte(CH_CAN);
            send_byte(8'($urandom_range(0, 255)));
        end
        else if (roll < 80)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
        else
            repeat ($urandom_range(1, 8)) send_tick();
    endtask

    task automatic run_random_phase();
        int w0;
        w0 = words_sent;
        while (words_sent - w0 < PHASE_MIN_WORDS)
            send_random_sequence();
    endtask

    // Drop valid and wait until every reply is out and the core is quiet
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (reply_sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] index, input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        reply_sb.write_reg(index, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_config(input logic [31:0] hdr_ticks, input logic [31:0] byte_ticks,
                                input logic [7:0] err_max);
        write_cfg(CFG_HDR_TMO, hdr_ticks);
        write_cfg(CFG_BYTE_TMO, byte_ticks);
        write_cfg(CFG_MAX_ERR, {24'd0, err_max});
    endtask

    initial
    begin : main_flow
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_HDR_TMO;
        cfg_data     = '0;
        idle_en      = 1'b1;
        hold_request = 1'b0;
        words_sent   = 0;
        reply_sb     = new();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: header replies, cancel paths, ticks below the limit
        send_byte(CH_EOT);
        send_byte(CH_ABORT);
        send_byte(CH_CAN);
        send_byte(CH_CAN);
        send_byte(CH_CAN);
        send_byte(8'h00);
        send_byte(8'hFF);
        repeat (3) send_tick();

        // Receiver holds off while aborts pile up and back-pressure the input
        hold_request = 1'b1;
        repeat (6) send_byte(CH_ABORT);
        settle();

        // Short timeouts, one error allowed before a double cancel
        apply_config(32'd2, 32'd4, 8'd1);
        repeat (2) send_tick();
        send_packet(reply_sb.next_seq(), 1'b0, 1'b0, 1'b1);
        send_packet(reply_sb.next_seq(), 1'b0, 1'b1, 1'b0);
        send_byte(CH_SOH);
        repeat (3) send_byte(8'($urandom_range(0, 255)));
        repeat (4) send_tick();
        send_byte(8'h80);
        settle();

        // Random traffic over several settings, extremes included
        apply_config(32'd3, 32'd2, 8'd0);
        run_random_phase();
        settle();

        apply_config(32'd1, 32'd1, 8'd255);
        run_random_phase();
        settle();

        apply_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd2);
        run_random_phase();
        settle();

        // Final part without idling
        idle_en = 1'b0;
        apply_config(32'd6, 32'd5, 8'd3);
        run_random_phase();
        settle();
        repeat (16) @(posedge clk);

        if (reply_sb.fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== xmodem_crc_packet_receiver_core.f =====
design/xcrc_pkg.sv
design/xcrc_crc.sv
design/xcrc_ctrl.sv
design/xcrc_fifo.sv
design/xmodem_crc_packet_receiver_core.sv
dv/xmodem_crc_packet_receiver_core_tb.sv
